@@ design/scvm_pkg.sv @@
// scvm_pkg: shared types, constants and register indexes of the swing crossfade
// volume mapper. No dependencies; imported by every module of the block.
`default_nettype none
package scvm_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_THRESHOLD    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_THRESHOLD     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CROSSFADE_LOW     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CROSSFADE_HIGH    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GRAVITY_INFLUENCE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_HUM_BASE_VOLUME   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_HUM_MAX_DUCKING   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWAP_MIN_VOLUME   = 3'd7;

  // register reset values
  localparam logic [15:0] RST_IDLE_THRESHOLD    = 16'd256;
  localparam logic [15:0] RST_MAX_THRESHOLD     = 16'd1024;
  localparam logic [15:0] RST_CROSSFADE_LOW     = 16'd256;
  localparam logic [15:0] RST_CROSSFADE_HIGH    = 16'd1024;
  localparam logic [15:0] RST_GRAVITY_INFLUENCE = 16'd0;
  localparam logic [13:0] RST_HUM_BASE_VOLUME   = 14'd16383;
  localparam logic [15:0] RST_HUM_MAX_DUCKING   = 16'd8192;
  localparam logic [15:0] RST_SWAP_MIN_VOLUME   = 16'd32768;

  localparam logic [16:0] UNITY16          = 17'h1_0000;
  localparam logic [30:0] UNITY30          = 31'h4000_0000;
  localparam logic [31:0] SWAP_COOLDOWN_MS = 32'd500;

  // divider runs one quotient bit per cycle
  localparam int unsigned DIV_W = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic [15:0]        kinetic_energy;
    logic signed [15:0] orientation;
    logic               burst;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [13:0] swing_low_volume;
    logic [13:0] swing_high_volume;
    logic [13:0] hum_volume;
    logic        burst_trigger;
    logic        swap_request;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MV_START,
    ST_MV_WAIT,
    ST_XF_START,
    ST_XF_WAIT,
    ST_GRAV,
    ST_MIX,
    ST_LO,
    ST_HI,
    ST_DUCK,
    ST_RATIO,
    ST_HUM,
    ST_HUM_TAKE,
    ST_DONE
  } scvm_state_t;

endpackage
`default_nettype wire

@@ design/scvm_div.sv @@
// scvm_div: restoring divider, (num << 16) / den with num < den, one bit per cycle.
// Depends on scvm_pkg for the request struct and widths.
`default_nettype none
module scvm_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire scvm_pkg::div_req_t          req,
  output logic                             done,
  output logic [scvm_pkg::DIV_W-1:0]       quot
);
  import scvm_pkg::*;

  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     den_r;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_W:0]       rem2;

  always_comb begin
    rem2 = {rem_r, 1'b0};
    if (rem2 >= {1'b0, den_r}) begin
      rem_nxt = DIV_W'(rem2 - {1'b0, den_r});
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem2[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire

@@ design/scvm_mul.sv @@
// scvm_mul: shared signed multiplier with a registered product.
// Depends on scvm_pkg for the operand struct and widths.
`default_nettype none
module scvm_mul (
  input  wire logic                             clk,
  input  wire scvm_pkg::mul_req_t               req,
  output logic signed [scvm_pkg::MUL_P_W-1:0]   prod
);
  import scvm_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

@@ design/swing_crossfade_volume_mapper.sv @@
// swing_crossfade_volume_mapper: top level, config registers, sequencer and swap state.
// Depends on scvm_pkg, scvm_div and scvm_mul.
//
//   channel | ports                          | transfer when
//   input   | in_valid, in_ready, in_data    | in_valid && in_ready
//   result  | out_valid, out_ready, out_data | out_valid && out_ready
//   config  | cfg_we, cfg_addr, cfg_wdata    | cfg_we
//
// one sample at a time: from input transfer to result the sequencer steps through its
// states in turn, holding the shared divider until done for each band that needs a
// division; the five products pass through the shared multiplier in turn.
// ready only while the sequencer is idle; a held result does not block the next input.
// synchronous active-low reset; no clearing pass.
`default_nettype none
module swing_crossfade_volume_mapper (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire scvm_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output scvm_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [scvm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [scvm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import scvm_pkg::*;

  // config
  logic [15:0] idle_thr_r, max_thr_r, xf_low_r, xf_high_r, grav_r, hum_duck_r, swap_min_r;
  logic [13:0] hum_base_r;

  // control
  scvm_state_t st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        swap_armed_r, swap_armed_nxt;
  logic        was_moving_r, was_moving_nxt;
  logic [31:0] last_time_r, last_time_nxt;

  // payload
  in_item_t    item_r, item_nxt;
  logic [16:0] mv_r, mv_nxt;
  logic [16:0] base_r, base_nxt;
  logic [16:0] mix_r, mix_nxt;
  logic [13:0] vl_r, vl_nxt;
  logic [13:0] vh_r, vh_nxt;
  logic [30:0] ratio_r, ratio_nxt;
  logic [13:0] hum_r, hum_nxt;
  out_item_t   out_data_r, out_data_nxt;

  div_req_t                  div_req;
  logic                      div_done;
  logic [DIV_W-1:0]          div_quot;
  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] prod;

  // band evaluation for whichever band the sequencer is on
  logic [15:0] band_lo, band_hi;
  logic        band_need_div;
  logic [16:0] band_direct;

  logic [46:0]        vol_scaled;
  logic signed [19:0] gmod;
  logic signed [20:0] mix_sum;
  logic [32:0]        duck;
  logic [31:0]        idle_ms;
  logic               swap_now;

  scvm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  scvm_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .prod(prod)
  );

  always_comb begin
    if (st_r == ST_XF_START) begin
      band_lo = xf_low_r;
      band_hi = xf_high_r;
    end else begin
      band_lo = idle_thr_r;
      band_hi = max_thr_r;
    end
    band_need_div = 1'b0;
    band_direct   = '0;
    // empty or inverted band is a step at the low bound
    if (band_hi <= band_lo) begin
      band_direct = (item_r.kinetic_energy > band_lo) ? UNITY16 : '0;
    end else if (item_r.kinetic_energy <= band_lo) begin
      band_direct = '0;
    end else if (item_r.kinetic_energy >= band_hi) begin
      band_direct = UNITY16;
    end else begin
      band_need_div = 1'b1;
    end
  end

  always_comb begin
    vol_scaled = {prod[32:0], 14'b0} - {14'b0, prod[32:0]};
    gmod       = prod[31:12];
    mix_sum    = $signed({4'b0, base_r}) + $signed({gmod[19], gmod});
    duck       = prod[32:0];
    idle_ms    = item_r.time_ms - last_time_r;
  end

  always_comb begin
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    swap_armed_nxt = swap_armed_r;
    was_moving_nxt = was_moving_r;
    last_time_nxt  = last_time_r;
    item_nxt       = item_r;
    mv_nxt         = mv_r;
    base_nxt       = base_r;
    mix_nxt        = mix_r;
    vl_nxt         = vl_r;
    vh_nxt         = vh_r;
    ratio_nxt      = ratio_r;
    hum_nxt        = hum_r;
    out_data_nxt   = out_data_r;
    div_req.start  = 1'b0;
    div_req.num    = DIV_W'(item_r.kinetic_energy - band_lo);
    div_req.den    = DIV_W'(band_hi - band_lo);
    mul_req.a      = '0;
    mul_req.b      = '0;
    in_ready       = 1'b0;
    swap_now       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          st_nxt   = ST_MV_START;
        end
      end
      ST_MV_START: begin
        if (band_need_div) begin
          div_req.start = 1'b1;
          st_nxt        = ST_MV_WAIT;
        end else begin
          mv_nxt = band_direct;
          st_nxt = ST_XF_START;
        end
      end
      ST_MV_WAIT: begin
        if (div_done) begin
          mv_nxt = {1'b0, div_quot};
          st_nxt = ST_XF_START;
        end
      end
      ST_XF_START: begin
        if (band_need_div) begin
          div_req.start = 1'b1;
          st_nxt        = ST_XF_WAIT;
        end else begin
          base_nxt = band_direct;
          st_nxt   = ST_GRAV;
        end
      end
      ST_XF_WAIT: begin
        if (div_done) begin
          base_nxt = {1'b0, div_quot};
          st_nxt   = ST_GRAV;
        end
      end
      ST_GRAV: begin
        mul_req.a = MUL_A_W'(item_r.orientation);
        mul_req.b = MUL_B_W'($signed(grav_r));
        st_nxt    = ST_MIX;
      end
      ST_MIX: begin
        // orientation term floors toward minus infinity via the arithmetic shift
        if (mix_sum[20]) begin
          mix_nxt = '0;
        end else if (mix_sum > $signed({4'b0, UNITY16})) begin
          mix_nxt = UNITY16;
        end else begin
          mix_nxt = mix_sum[16:0];
        end
        st_nxt = ST_LO;
      end
      ST_LO: begin
        mul_req.a = $signed({1'b0, mv_r});
        mul_req.b = $signed({15'b0, 17'(UNITY16 - mix_r)});
        st_nxt    = ST_HI;
      end
      ST_HI: begin
        // x * 16383 as (x << 14) - x
        vl_nxt    = vol_scaled[45:32];
        mul_req.a = $signed({1'b0, mv_r});
        mul_req.b = $signed({15'b0, mix_r});
        st_nxt    = ST_DUCK;
      end
      ST_DUCK: begin
        vh_nxt    = vol_scaled[45:32];
        mul_req.a = $signed({1'b0, mv_r});
        mul_req.b = $signed({16'b0, hum_duck_r});
        st_nxt    = ST_RATIO;
      end
      ST_RATIO: begin
        // ducking past unity silences the hum
        if (duck >= {2'b0, UNITY30}) begin
          ratio_nxt = '0;
        end else begin
          ratio_nxt = UNITY30 - duck[30:0];
        end
        st_nxt = ST_HUM;
      end
      ST_HUM: begin
        mul_req.a = $signed({4'b0, hum_base_r});
        mul_req.b = $signed({1'b0, ratio_r});
        st_nxt    = ST_HUM_TAKE;
      end
      ST_HUM_TAKE: begin
        hum_nxt = prod[43:30];
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          if ({15'b0, mv_r} > {16'b0, swap_min_r}) begin
            swap_armed_nxt = 1'b1;
          end
          if (mv_r != '0) begin
            was_moving_nxt = 1'b1;
            last_time_nxt  = item_r.time_ms;
          end else if (was_moving_r) begin
            was_moving_nxt = 1'b0;
          end else if (swap_armed_r && (idle_ms >= SWAP_COOLDOWN_MS)) begin
            swap_armed_nxt = 1'b0;
            swap_now       = 1'b1;
          end
          out_data_nxt.swing_low_volume  = vl_r;
          out_data_nxt.swing_high_volume = vh_r;
          out_data_nxt.hum_volume        = hum_r;
          out_data_nxt.burst_trigger     = item_r.burst;
          out_data_nxt.swap_request      = swap_now;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_valid_r  <= 1'b0;
      swap_armed_r <= 1'b0;
      was_moving_r <= 1'b0;
      last_time_r  <= '0;
    end else begin
      st_r         <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      swap_armed_r <= swap_armed_nxt;
      was_moving_r <= was_moving_nxt;
      last_time_r  <= last_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    mv_r       <= mv_nxt;
    base_r     <= base_nxt;
    mix_r      <= mix_nxt;
    vl_r       <= vl_nxt;
    vh_r       <= vh_nxt;
    ratio_r    <= ratio_nxt;
    hum_r      <= hum_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_thr_r <= RST_IDLE_THRESHOLD;
      max_thr_r  <= RST_MAX_THRESHOLD;
      xf_low_r   <= RST_CROSSFADE_LOW;
      xf_high_r  <= RST_CROSSFADE_HIGH;
      grav_r     <= RST_GRAVITY_INFLUENCE;
      hum_base_r <= RST_HUM_BASE_VOLUME;
      hum_duck_r <= RST_HUM_MAX_DUCKING;
      swap_min_r <= RST_SWAP_MIN_VOLUME;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IDLE_THRESHOLD:    idle_thr_r <= cfg_wdata;
        CFG_MAX_THRESHOLD:     max_thr_r  <= cfg_wdata;
        CFG_CROSSFADE_LOW:     xf_low_r   <= cfg_wdata;
        CFG_CROSSFADE_HIGH:    xf_high_r  <= cfg_wdata;
        CFG_GRAVITY_INFLUENCE: grav_r     <= cfg_wdata;
        CFG_HUM_BASE_VOLUME:   hum_base_r <= cfg_wdata[13:0];
        CFG_HUM_MAX_DUCKING:   hum_duck_r <= cfg_wdata;
        CFG_SWAP_MIN_VOLUME:   swap_min_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider finishes only while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_MV_WAIT || st_r == ST_XF_WAIT))
    else $error("divider done outside a wait state");

  // a new result is only loaded from the final step
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_DONE)
    else $error("result loaded outside the final step");

  // a swap request leaves the swap state disarmed and idle
  a_swap_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.swap_request) |-> (!swap_armed_r && !was_moving_r))
    else $error("swap request with swap state still set");

endmodule
`default_nettype wire
